// File: design/weo_pkg.sv
// shared constants, types and tables for the wheel encoder odometry block
package weo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int MUL_W        = 33;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int CORD_W       = 33;
    localparam int ACC_W        = 68;
    localparam int CEN_W        = 34;
    localparam int CFG_IDX_W    = 8;

    localparam logic [31:0] MM_PER_TICK_RST = 32'd5033165;
    localparam logic [31:0] TURN_GAIN_RST   = 32'd2187321856;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [1:0] CMD_LEFT   = 2'd0;
    localparam logic [1:0] CMD_RIGHT  = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_TICK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN   = 8'd1;

    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic                     done;
        logic signed [CORD_W-1:0] cos_v;
        logic signed [CORD_W-1:0] sin_v;
    } t_cordic_res;

endpackage

// File: design/weo_mul.sv
// shared signed multiplier with registered product
module weo_mul
    import weo_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: design/weo_cordic.sv
// iterative rotation cordic giving cos and sin of a binary angle in q1.30
module weo_cordic
    import weo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_angle,
    output t_cordic_res o_res
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic signed [CORD_W-1:0] r_x, r_y, r_z;
    logic [STEP_W-1:0]        r_i;
    logic                     r_busy, r_done, r_flip;

    logic signed [CORD_W-1:0] w_xs, w_ys, w_at, w_z0;
    logic                     w_flip;
    logic [31:0]              w_a;

    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_at   = {1'b0, ATAN_TAB[r_i]};
    // second and third quadrant are turned by a half turn
    assign w_flip = i_angle[31] ^ i_angle[30];
    assign w_a    = w_flip ? {~i_angle[31], i_angle[30:0]} : i_angle;
    assign w_z0   = {w_a[31], w_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_i == LAST_STEP);
            if (i_start) begin
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= w_z0;
                r_flip <= w_flip;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[CORD_W-1]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end
                if (r_i == LAST_STEP) begin
                    r_busy <= 1'b0;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.cos_v = r_flip ? -r_x : r_x;
    assign o_res.sin_v = r_flip ? -r_y : r_y;

endmodule

// File: design/wheel_encoder_odometry.sv
// top level: tick counters, pose sequencer, configuration registers
// Two wheel tick counters and a differential-drive pose (x, y in signed Q16.16 mm,
// heading as a 32-bit binary angle). Every command transfer returns one result with
// the pose and counts after the command. Edge and clear commands give their result
// in the cycle after the transfer. An update gives its result after it has made eight
// passes through the one shared 33x33 multiplier (centre distance, heading step, x and
// y steps) and run the 24-step CORDIC loop, with a state to load it and one to wait for
// it to finish. The block takes one command at a time and is ready again in the
// cycle after the previous result has been transferred.
module wheel_encoder_odometry
    import weo_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_command,
    input  logic                 i_b_level,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_pos_x,
    output logic signed [31:0]   o_pos_y,
    output logic [31:0]          o_heading,
    output logic signed [31:0]   o_left_count,
    output logic signed [31:0]   o_right_count,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_M3   = 4'd3;
    localparam logic [3:0] S_M4   = 4'd4;
    localparam logic [3:0] S_M5   = 4'd5;
    localparam logic [3:0] S_M6   = 4'd6;
    localparam logic [3:0] S_C0   = 4'd7;
    localparam logic [3:0] S_CW   = 4'd8;
    localparam logic [3:0] S_P1   = 4'd9;
    localparam logic [3:0] S_P2   = 4'd10;
    localparam logic [3:0] S_P3   = 4'd11;
    localparam logic [3:0] S_P4   = 4'd12;
    localparam logic [3:0] S_P5   = 4'd13;
    localparam logic [3:0] S_P6   = 4'd14;

    localparam logic signed [PROD_W-1:0] CEN_MAX = PROD_W'(64'sd4294967296);
    localparam logic signed [PROD_W-1:0] CEN_MIN = PROD_W'(-64'sd4294967296);

    logic [3:0]               r_state, n_state;
    logic                     r_out_valid, n_out_valid;
    logic [31:0]              r_mm_per_tick, r_turn_gain;
    logic [31:0]              r_left, n_left, r_right, n_right;
    logic [31:0]              r_left_prev, n_left_prev, r_right_prev, n_right_prev;
    logic signed [31:0]       r_pose_x, n_pose_x, r_pose_y, n_pose_y;
    logic [31:0]              r_heading, n_heading;
    logic signed [MUL_W-1:0]  r_sum, n_sum, r_diff, n_diff;
    logic signed [CEN_W-1:0]  r_cen, n_cen;
    logic [63:0]              r_q, n_q;
    logic [31:0]              r_hq, n_hq;
    logic signed [ACC_W-1:0]  r_acc, n_acc;

    logic                     w_in_xfer;
    logic [31:0]              w_dl, w_dr;
    logic signed [MUL_W-1:0]  w_ma, w_mb, w_mm, w_tg, w_ch, w_cl;
    logic signed [PROD_W-1:0] w_p, w_pcen;
    logic signed [ACC_W-1:0]  w_pacc;
    t_cordic_res              w_cord;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] pose,
                                                   input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-30:0] step;
        logic signed [ACC_W-30:0] tot;
        step = (ACC_W-29)'(acc >>> 30);
        tot  = (ACC_W-29)'(pose) + step;
        if (tot > (ACC_W-29)'(32'sh7FFFFFFF)) begin
            sat_add = 32'sh7FFFFFFF;
        end else if (tot < (ACC_W-29)'(-33'sh80000000)) begin
            sat_add = -32'sh80000000;
        end else begin
            sat_add = tot[31:0];
        end
    endfunction

    assign w_in_xfer  = i_in_valid & o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) & ~r_out_valid;
    assign w_dl       = r_left - r_left_prev;
    assign w_dr       = r_right - r_right_prev;
    assign w_mm       = {1'b0, r_mm_per_tick};
    assign w_tg       = {1'b0, r_turn_gain};
    assign w_ch       = MUL_W'(r_cen >>> 16);
    assign w_cl       = {{(MUL_W-16){1'b0}}, r_cen[15:0]};
    assign w_pcen     = w_p >>> 9;
    assign w_pacc     = ACC_W'(w_p) <<< 16;

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_M1: begin
                w_ma = r_sum;
                w_mb = w_mm;
            end
            S_M2: begin
                w_ma = r_diff;
                w_mb = w_mm;
            end
            S_M4: begin
                w_ma = {1'b0, r_q[31:0]};
                w_mb = w_tg;
            end
            S_M5: begin
                w_ma = {r_q[63], r_q[63:32]};
                w_mb = w_tg;
            end
            S_P1: begin
                w_ma = w_ch;
                w_mb = w_cord.cos_v;
            end
            S_P2: begin
                w_ma = w_cl;
                w_mb = w_cord.cos_v;
            end
            S_P3: begin
                w_ma = w_ch;
                w_mb = w_cord.sin_v;
            end
            S_P4: begin
                w_ma = w_cl;
                w_mb = w_cord.sin_v;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    weo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    weo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_C0),
        .i_angle (r_heading),
        .o_res   (w_cord)
    );

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_left       = r_left;
        n_right      = r_right;
        n_left_prev  = r_left_prev;
        n_right_prev = r_right_prev;
        n_pose_x     = r_pose_x;
        n_pose_y     = r_pose_y;
        n_heading    = r_heading;
        n_sum        = r_sum;
        n_diff       = r_diff;
        n_cen        = r_cen;
        n_q          = r_q;
        n_hq         = r_hq;
        n_acc        = r_acc;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    case (i_command)
                        CMD_LEFT: begin
                            n_left      = i_b_level ? r_left - 32'd1 : r_left + 32'd1;
                            n_out_valid = 1'b1;
                        end
                        CMD_RIGHT: begin
                            n_right     = i_b_level ? r_right + 32'd1 : r_right - 32'd1;
                            n_out_valid = 1'b1;
                        end
                        CMD_UPDATE: begin
                            n_sum        = MUL_W'($signed(w_dl)) + MUL_W'($signed(w_dr));
                            n_diff       = MUL_W'($signed(w_dr)) - MUL_W'($signed(w_dl));
                            n_left_prev  = r_left;
                            n_right_prev = r_right;
                            n_state      = S_M1;
                        end
                        default: begin
                            n_left       = '0;
                            n_right      = '0;
                            n_left_prev  = '0;
                            n_right_prev = '0;
                            n_pose_x     = '0;
                            n_pose_y     = '0;
                            n_heading    = '0;
                            n_out_valid  = 1'b1;
                        end
                    endcase
                end
            end
            S_M1: n_state = S_M2;
            S_M2: begin
                // centre distance in q16.16, clamped to plus or minus 2^32
                if (w_pcen > CEN_MAX) begin
                    n_cen = CEN_W'(CEN_MAX);
                end else if (w_pcen < CEN_MIN) begin
                    n_cen = CEN_W'(CEN_MIN);
                end else begin
                    n_cen = CEN_W'(w_pcen);
                end
                n_state = S_M3;
            end
            S_M3: begin
                n_q     = w_p[63:0];
                n_state = S_M4;
            end
            S_M4: n_state = S_M5;
            S_M5: begin
                n_hq    = w_p[63:32];
                n_state = S_M6;
            end
            S_M6: begin
                n_heading = r_heading + r_hq + w_p[31:0];
                n_state   = S_C0;
            end
            S_C0: n_state = S_CW;
            S_CW: begin
                if (w_cord.done) begin
                    n_state = S_P1;
                end
            end
            S_P1: n_state = S_P2;
            S_P2: begin
                n_acc   = w_pacc;
                n_state = S_P3;
            end
            S_P3: begin
                n_acc   = r_acc + ACC_W'(w_p);
                n_state = S_P4;
            end
            S_P4: begin
                n_pose_x = sat_add(r_pose_x, r_acc);
                n_acc    = w_pacc;
                n_state  = S_P5;
            end
            S_P5: begin
                n_acc   = r_acc + ACC_W'(w_p);
                n_state = S_P6;
            end
            S_P6: begin
                n_pose_y    = sat_add(r_pose_y, r_acc);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_mm_per_tick <= MM_PER_TICK_RST;
            r_turn_gain   <= TURN_GAIN_RST;
            r_left        <= '0;
            r_right       <= '0;
            r_left_prev   <= '0;
            r_right_prev  <= '0;
            r_pose_x      <= '0;
            r_pose_y      <= '0;
            r_heading     <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_left       <= n_left;
            r_right      <= n_right;
            r_left_prev  <= n_left_prev;
            r_right_prev <= n_right_prev;
            r_pose_x     <= n_pose_x;
            r_pose_y     <= n_pose_y;
            r_heading    <= n_heading;
            if (i_cfg_we && i_cfg_index == REG_MM_PER_TICK) begin
                r_mm_per_tick <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == REG_TURN_GAIN) begin
                r_turn_gain <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_diff <= n_diff;
        r_cen  <= n_cen;
        r_q    <= n_q;
        r_hq   <= n_hq;
        r_acc  <= n_acc;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_pose_x;
    assign o_pos_y       = r_pose_y;
    assign o_heading     = r_heading;
    assign o_left_count  = r_left;
    assign o_right_count = r_right;

`ifndef SYNTHESIS
    a_cordic_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cord.done |-> r_state == S_CW)
        else $error("cordic finished outside its wait state");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(w_in_xfer) || $past(r_state) == S_P6))
        else $error("result raised without a transfer or finished update");

    a_heading_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !w_in_xfer) |=> $stable(r_heading))
        else $error("heading changed while idle");
`endif

endmodule
